/* hw/rtl/krt_pkg.sv */
// Shared types and constants for the keyed record table.
package krt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = 5;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_EXISTS = 3'd3;
	localparam logic [2:0] OP_LIST   = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] year;
		logic [31:0] course_a;
		logic [7:0]  grade_a;
		logic [31:0] course_b;
		logic [7:0]  grade_b;
		logic [31:0] course_c;
		logic [7:0]  grade_c;
	} rec_t;

	typedef struct packed {
		logic        rd_en;
		idx_t        rd_addr;
		logic        wr_en;
		idx_t        wr_addr;
	} mem_ctl_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] key_in;
		logic [15:0] year_in;
		logic [31:0] course_a_in;
		logic [7:0]  grade_a_in;
		logic [31:0] course_b_in;
		logic [7:0]  grade_b_in;
		logic [31:0] course_c_in;
		logic [7:0]  grade_c_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] key_out;
		logic [15:0] year_out;
		logic [31:0] course_a_out;
		logic [7:0]  grade_a_out;
		logic [31:0] course_b_out;
		logic [7:0]  grade_b_out;
		logic [31:0] course_c_out;
		logic [7:0]  grade_c_out;
		cnt_t        entry_count;
		logic        table_full;
		logic        last;
	} out_word_t;

endpackage

/* hw/rtl/krt_store.sv */
// Record store: one write port, one registered read port.
module krt_store (
	input  logic             clk,
	input  krt_pkg::mem_ctl_t ctl,
	input  krt_pkg::rec_t    wr_data,
	output krt_pkg::rec_t    rd_data
);
	import krt_pkg::*;

	rec_t mem_q [CAPACITY];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[ctl.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/keyed_record_table_core.sv */
// Steps: add and unknown codes go from dispatch straight to emit; search reads and compares
// each probed record in turn, delete then reads and writes each record moved down, and list
// reads, loads and emits each key in turn. Output stalls hold the block in emit.
// Flow: one word at a time; the next word is taken the cycle after the last result is
// registered.
// Reset: occupancy clears at once; the record store is not cleared and needs no sweep.
module keyed_record_table_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  krt_pkg::in_word_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output krt_pkg::out_word_t rsp
);
	import krt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_LIST_RD,
		S_LIST_LD,
		S_EMIT
	} state_t;

	state_t    state_q;
	in_word_t  item_q;
	idx_t      idx_q;
	cnt_t      count_q;
	out_word_t res_q;
	out_word_t rsp_q;
	logic      rsp_valid_q;

	mem_ctl_t  mem_ctl;
	rec_t      new_rec;
	rec_t      wr_rec;
	rec_t      rd_rec;
	logic      full;
	logic      out_free;
	logic      emit;
	out_word_t res_out;
	cnt_t      idx_ext;

	function automatic out_word_t make_res(logic [1:0] st, logic with_rec, rec_t r,
	                                       logic [31:0] k, logic lst);
		out_word_t w;
		w              = '0;
		w.status       = st;
		w.key_out      = k;
		if (with_rec) begin
			w.year_out     = r.year;
			w.course_a_out = r.course_a;
			w.grade_a_out  = r.grade_a;
			w.course_b_out = r.course_b;
			w.grade_b_out  = r.grade_b;
			w.course_c_out = r.course_c;
			w.grade_c_out  = r.grade_c;
		end
		w.last         = lst;
		return w;
	endfunction

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign emit     = (state_q == S_EMIT) && out_free;
	assign idx_ext  = CNT_W'(idx_q);

	always_comb begin
		res_out             = res_q;
		res_out.entry_count = count_q;
		res_out.table_full  = full;
	end

	always_comb begin
		new_rec.key      = item_q.key_in;
		new_rec.year     = item_q.year_in;
		new_rec.course_a = item_q.course_a_in;
		new_rec.grade_a  = item_q.grade_a_in;
		new_rec.course_b = item_q.course_b_in;
		new_rec.grade_b  = item_q.grade_b_in;
		new_rec.course_c = item_q.course_c_in;
		new_rec.grade_c  = item_q.grade_c_in;
	end

	always_comb begin
		mem_ctl.rd_en   = (state_q == S_SRCH_RD) || (state_q == S_SHIFT_RD) ||
		                  (state_q == S_LIST_RD);
		mem_ctl.rd_addr = (state_q == S_SHIFT_RD) ? idx_q + idx_t'(1) : idx_q;
		mem_ctl.wr_en   = ((state_q == S_DISPATCH) && (item_q.operation == OP_ADD) && !full) ||
		                  (state_q == S_SHIFT_WR);
		mem_ctl.wr_addr = (state_q == S_SHIFT_WR) ? idx_q : count_q[IDX_W-1:0];
		wr_rec          = (state_q == S_SHIFT_WR) ? rd_rec : new_rec;
	end

	krt_store u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_data (wr_rec),
		.rd_data (rd_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						idx_q   <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (item_q.operation)
						OP_ADD: begin
							if (full) begin
								res_q <= make_res(ST_FULL, 1'b0, rd_rec, '0, 1'b1);
							end else begin
								count_q <= count_q + CNT_W'(1);
								res_q   <= make_res(ST_OK, 1'b0, rd_rec, '0, 1'b1);
							end
							state_q <= S_EMIT;
						end
						OP_DELETE, OP_READ, OP_EXISTS: begin
							if (count_q == '0) begin
								res_q   <= make_res(ST_NOT_FOUND, 1'b0, rd_rec, '0, 1'b1);
								state_q <= S_EMIT;
							end else begin
								state_q <= S_SRCH_RD;
							end
						end
						OP_LIST: begin
							if (count_q == '0) begin
								res_q   <= make_res(ST_EMPTY, 1'b0, rd_rec, '0, 1'b1);
								state_q <= S_EMIT;
							end else begin
								state_q <= S_LIST_RD;
							end
						end
						default: begin
							res_q   <= make_res(ST_OK, 1'b0, rd_rec, '0, 1'b1);
							state_q <= S_EMIT;
						end
					endcase
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (rd_rec.key == item_q.key_in) begin
						case (item_q.operation)
							OP_READ: begin
								res_q   <= make_res(ST_OK, 1'b1, rd_rec, rd_rec.key, 1'b1);
								state_q <= S_EMIT;
							end
							OP_DELETE: begin
								if (idx_ext + CNT_W'(1) < count_q) begin
									state_q <= S_SHIFT_RD;
								end else begin
									count_q <= count_q - CNT_W'(1);
									res_q   <= make_res(ST_OK, 1'b0, rd_rec, '0, 1'b1);
									state_q <= S_EMIT;
								end
							end
							default: begin
								res_q   <= make_res(ST_OK, 1'b0, rd_rec, '0, 1'b1);
								state_q <= S_EMIT;
							end
						endcase
					end else if (idx_ext + CNT_W'(1) == count_q) begin
						res_q   <= make_res(ST_NOT_FOUND, 1'b0, rd_rec, '0, 1'b1);
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + idx_t'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					idx_q <= idx_q + idx_t'(1);
					if (idx_ext + CNT_W'(2) < count_q) begin
						state_q <= S_SHIFT_RD;
					end else begin
						count_q <= count_q - CNT_W'(1);
						res_q   <= make_res(ST_OK, 1'b0, rd_rec, '0, 1'b1);
						state_q <= S_EMIT;
					end
				end
				S_LIST_RD: begin
					state_q <= S_LIST_LD;
				end
				S_LIST_LD: begin
					res_q   <= make_res(ST_OK, 1'b0, rd_rec, rd_rec.key,
					                    idx_ext + CNT_W'(1) == count_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_q <= res_out;
						if (res_q.last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + idx_t'(1);
							state_q <= S_LIST_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/krt_chk.sv */
// Port checker for the keyed record table, bound to the top level.
module krt_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input krt_pkg::in_word_t  req,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input krt_pkg::out_word_t rsp
);
	import krt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result word changed or dropped");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.table_full == (rsp.entry_count == CNT_W'(CAPACITY))))
		else $error("full flag disagrees with entry count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count above capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("word accepted while previous word still in work");

	a_add_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> rsp.table_full && rsp.last)
		else $error("full status without full table");

endmodule

bind keyed_record_table_core krt_chk u_krt_chk (.*);

/* sim/keyed_record_table_core_test.sv */
// Self-checking testbench for keyed_record_table_core: directed and random table traffic.
module keyed_record_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import krt_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;
	localparam int HOLD_CYCLES  = 150;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	in_word_t  req;
	logic      rsp_valid;
	logic      rsp_stall;
	out_word_t rsp;

	rec_t      table_rec [CAPACITY];
	int        table_count;
	out_word_t pending_rsp [$];

	int errors;
	int words_sent;
	int results_checked;
	int peak_count;
	int full_refusals;
	int list_keys;
	int hold_cycles;
	bit tx_idle_on;
	bit rx_idle_on;

	keyed_record_table_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void report_failure(string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endfunction

	function automatic string fmt_rsp(out_word_t r);
		return $sformatf("st=%0d key=%h yr=%h a=%h/%h b=%h/%h c=%h/%h cnt=%0d full=%b last=%b",
			r.status, r.key_out, r.year_out, r.course_a_out, r.grade_a_out,
			r.course_b_out, r.grade_b_out, r.course_c_out, r.grade_c_out,
			r.entry_count, r.table_full, r.last);
	endfunction

	function automatic out_word_t rsp_word(logic [1:0] st, logic [31:0] key, rec_t rec,
			logic last);
		out_word_t r;
		r.status       = st;
		r.key_out      = key;
		r.year_out     = rec.year;
		r.course_a_out = rec.course_a;
		r.grade_a_out  = rec.grade_a;
		r.course_b_out = rec.course_b;
		r.grade_b_out  = rec.grade_b;
		r.course_c_out = rec.course_c;
		r.grade_c_out  = rec.grade_c;
		r.entry_count  = cnt_t'(table_count);
		r.table_full   = (table_count >= CAPACITY);
		r.last         = last;
		return r;
	endfunction

	function automatic void predict_table_op(in_word_t w);
		int   hit;
		rec_t blank;
		blank = '0;
		hit = -1;
		for (int i = 0; i < table_count; i++)
			if (hit < 0 && table_rec[i].key == w.key_in)
				hit = i;
		case (w.operation)
			OP_ADD: begin
				if (table_count >= CAPACITY) begin
					full_refusals++;
					pending_rsp.push_back(rsp_word(ST_FULL, '0, blank, 1'b1));
				end else begin
					table_rec[table_count].key      = w.key_in;
					table_rec[table_count].year     = w.year_in;
					table_rec[table_count].course_a = w.course_a_in;
					table_rec[table_count].grade_a  = w.grade_a_in;
					table_rec[table_count].course_b = w.course_b_in;
					table_rec[table_count].grade_b  = w.grade_b_in;
					table_rec[table_count].course_c = w.course_c_in;
					table_rec[table_count].grade_c  = w.grade_c_in;
					table_count++;
					if (table_count > peak_count)
						peak_count = table_count;
					pending_rsp.push_back(rsp_word(ST_OK, '0, blank, 1'b1));
				end
			end
			OP_DELETE: begin
				if (hit < 0) begin
					pending_rsp.push_back(rsp_word(ST_NOT_FOUND, '0, blank, 1'b1));
				end else begin
					for (int i = hit; i < table_count - 1; i++)
						table_rec[i] = table_rec[i + 1];
					table_count--;
					pending_rsp.push_back(rsp_word(ST_OK, '0, blank, 1'b1));
				end
			end
			OP_READ: begin
				if (hit < 0)
					pending_rsp.push_back(rsp_word(ST_NOT_FOUND, '0, blank, 1'b1));
				else
					pending_rsp.push_back(rsp_word(ST_OK, table_rec[hit].key, table_rec[hit],
						1'b1));
			end
			OP_EXISTS: begin
				pending_rsp.push_back(rsp_word((hit < 0) ? ST_NOT_FOUND : ST_OK, '0, blank,
					1'b1));
			end
			OP_LIST: begin
				if (table_count == 0) begin
					pending_rsp.push_back(rsp_word(ST_EMPTY, '0, blank, 1'b1));
				end else begin
					for (int i = 0; i < table_count; i++) begin
						list_keys++;
						pending_rsp.push_back(rsp_word(ST_OK, table_rec[i].key, blank,
							i == table_count - 1));
					end
				end
			end
			default: begin
				pending_rsp.push_back(rsp_word(ST_OK, '0, blank, 1'b1));
			end
		endcase
	endfunction

	function automatic in_word_t noise_word(logic [2:0] op, logic [31:0] key);
		in_word_t w;
		w.operation   = op;
		w.key_in      = key;
		w.year_in     = 16'($urandom);
		w.course_a_in = $urandom;
		w.grade_a_in  = 8'($urandom);
		w.course_b_in = $urandom;
		w.grade_b_in  = 8'($urandom);
		w.course_c_in = $urandom;
		w.grade_c_in  = 8'($urandom);
		return w;
	endfunction

	function automatic in_word_t rec_word(logic [2:0] op, logic [31:0] key, logic [15:0] year,
			logic [31:0] course, logic [7:0] grade);
		in_word_t w;
		w.operation   = op;
		w.key_in      = key;
		w.year_in     = year;
		w.course_a_in = course;
		w.grade_a_in  = grade;
		w.course_b_in = course;
		w.grade_b_in  = grade;
		w.course_c_in = course;
		w.grade_c_in  = grade;
		return w;
	endfunction

	function automatic logic [31:0] stored_key();
		return table_rec[$urandom_range(0, table_count - 1)].key;
	endfunction

	function automatic in_word_t rand_table_word(int add_w);
		int          r;
		logic [2:0]  op;
		logic [31:0] key;
		r = $urandom_range(0, 99);
		if (r < add_w) begin
			op = OP_ADD;
			case ($urandom_range(0, 3))
				0: key = (table_count > 0) ? stored_key() : $urandom;
				1: key = $urandom_range(0, 7);
				default: key = $urandom;
			endcase
		end else begin
			r = $urandom_range(0, 99);
			if (r < 35)
				op = OP_DELETE;
			else if (r < 60)
				op = OP_READ;
			else if (r < 80)
				op = OP_EXISTS;
			else if (r < 92)
				op = OP_LIST;
			else
				op = OP_SPARE_LO + 3'($urandom_range(0, OP_SPARE_HI - OP_SPARE_LO));
			if (table_count > 0 && $urandom_range(0, 3) != 0)
				key = stored_key();
			else if ($urandom_range(0, 1) == 0)
				key = $urandom_range(0, 7);
			else
				key = $urandom;
		end
		return noise_word(op, key);
	endfunction

	task automatic send_word(input in_word_t w);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
		@(negedge clk);
		req_valid = 1'b1;
		req = w;
		do begin
			@(posedge clk);
		end while (req_stall);
		predict_table_op(w);
		words_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_word(noise_word(OP_LIST, $urandom));
		send_word(noise_word(OP_READ, $urandom));
		send_word(noise_word(OP_DELETE, $urandom));
		send_word(noise_word(OP_EXISTS, $urandom));
		wait_drained();
	endtask

	task automatic test_record_fields();
		send_word(rec_word(OP_ADD, 32'h0, 16'h0, 32'h0, 8'h0));
		send_word(rec_word(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
		send_word(rec_word(OP_ADD, 32'h0, 16'h1234, 32'hA5A5_0F0F, 8'h5A));
		send_word(noise_word(OP_READ, 32'h0));
		send_word(noise_word(OP_READ, 32'hFFFF_FFFF));
		send_word(noise_word(OP_EXISTS, 32'h0));
		send_word(noise_word(OP_EXISTS, 32'h5));
		send_word(noise_word(OP_LIST, 32'h0));
		send_word(noise_word(OP_DELETE, 32'h0));
		send_word(noise_word(OP_READ, 32'h0));
		send_word(noise_word(OP_DELETE, 32'hFFFF_FFFF));
		send_word(noise_word(OP_LIST, 32'hFFFF_FFFF));
		send_word(noise_word(OP_DELETE, 32'h5));
		wait_drained();
	endtask

	task automatic test_unused_codes();
		for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
			send_word(rec_word(3'(c), 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
		wait_drained();
	endtask

	task automatic test_full_table();
		while (table_count < CAPACITY)
			send_word(noise_word(OP_ADD, $urandom));
		send_word(noise_word(OP_ADD, $urandom));
		send_word(noise_word(OP_ADD, table_rec[0].key));
		send_word(noise_word(OP_LIST, $urandom));
		send_word(noise_word(OP_EXISTS, table_rec[CAPACITY - 1].key));
		send_word(noise_word(OP_READ, table_rec[CAPACITY - 1].key));
		send_word(noise_word(OP_DELETE, table_rec[0].key));
		send_word(noise_word(OP_ADD, $urandom));
		send_word(noise_word(OP_DELETE, table_rec[CAPACITY - 1].key));
		send_word(noise_word(OP_LIST, $urandom));
		wait_drained();
	endtask

	task automatic test_receiver_hold();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_cycles = HOLD_CYCLES;
		repeat (12)
			send_word(rand_table_word(50));
		wait_drained();
	endtask

	task automatic test_random_mix();
		int add_w [7];
		add_w = '{70, 25, 50, 85, 15, 45, 60};
		for (int p = 0; p < 7; p++) begin
			tx_idle_on = (p != 2) && ($urandom_range(0, 3) != 0);
			rx_idle_on = (p != 2) && ($urandom_range(0, 3) != 0);
			repeat (50)
				send_word(rand_table_word(add_w[p]));
			if (p % 2 == 1)
				wait_drained();
		end
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_stall = 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall = 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				rsp_stall = (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_checked++;
			if (pending_rsp.size() == 0) begin
				report_failure({"unexpected result: ", fmt_rsp(rsp)});
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.key_out !== want.key_out ||
						rsp.year_out !== want.year_out ||
						rsp.course_a_out !== want.course_a_out ||
						rsp.grade_a_out !== want.grade_a_out ||
						rsp.course_b_out !== want.course_b_out ||
						rsp.grade_b_out !== want.grade_b_out ||
						rsp.course_c_out !== want.course_c_out ||
						rsp.grade_c_out !== want.grade_c_out ||
						rsp.entry_count !== want.entry_count ||
						rsp.table_full !== want.table_full || rsp.last !== want.last)
					report_failure({"mismatch: want ", fmt_rsp(want), " got ", fmt_rsp(rsp)});
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_record_fields();
		test_unused_codes();
		test_full_table();
		test_receiver_hold();
		test_random_mix();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0)
			report_failure($sformatf("%0d results never arrived", pending_rsp.size()));
		$display("covered %0d words in, %0d results checked, %0d keys listed",
			words_sent, results_checked, list_keys);
		$display("peak occupancy %0d of %0d, %0d adds refused on a full table, %0d failures",
			peak_count, CAPACITY, full_refusals, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
